>>> sv/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

    localparam int CMD_W    = 3;
    localparam int OPND_W   = 32;
    localparam int WIDE_W   = 64;
    localparam int RDEN_W   = 31;
    localparam int CODE_W   = 2;
    localparam int S_DATA_W = 136;
    localparam int M_DATA_W = 72;
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_NEG  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_NORM = 3'd5;

    localparam logic [CODE_W-1:0] ST_OK       = 2'd0;
    localparam logic [CODE_W-1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [CODE_W-1:0] ST_OVERFLOW = 2'd2;

    localparam logic [CODE_W-1:0] ORD_LT = 2'd0;
    localparam logic [CODE_W-1:0] ORD_EQ = 2'd1;
    localparam logic [CODE_W-1:0] ORD_GT = 2'd2;

    typedef struct packed {
        logic              neg;
        logic [OPND_W-1:0] mag;
    } smag_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        smag_t            an;
        smag_t            ad;
        smag_t            bn;
        smag_t            bd;
        logic             err;
        logic             dens_ok;
    } item_t;

endpackage

>>> sv/rational_arithmetic_unit_top.sv
// Rational arithmetic unit top level: front end, item queue and back end.
// Sequence: queue, then multiply, compare and combine, binary gcd (one shift or
// subtract per cycle over 64-bit magnitudes), exact division and the output register.
// Throughput: one item at a time in the back end; an error item skips the gcd and the
// division; the queue takes up to two further items.
// Reset: aresetn synchronous, active low; clears queue, sequencer and output valid.
module rational_arithmetic_unit_top #(
    parameter int FIELD_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // cmd[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99], zeros above
    input  logic [rau_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // res_num[31:0], res_den[62:32], status[64:63], order[66:65], zeros above
    output logic [rau_pkg::M_DATA_W-1:0] m_tdata
);

    logic           q_push, q_full, q_pop, q_empty;
    rau_pkg::item_t push_item, head_item;

    rau_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    rau_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head_item (head_item)
    );

    rau_back #(
        .FIELD_WIDTH (FIELD_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[64:63] != rau_pkg::ST_OK) |-> (m_tdata[62:0] == '0))
        else $error("error result carries nonzero value");

    a_ok_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[64:63] == rau_pkg::ST_OK) |-> (m_tdata[62:32] != '0))
        else $error("good result with zero denominator");

    a_zero_num: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[64:63] == rau_pkg::ST_OK && m_tdata[31:0] == '0)
        |-> (m_tdata[62:32] == 31'd1))
        else $error("zero result not reduced to 0/1");

endmodule

>>> sv/rau_front.sv
// Front end: takes input items, splits operands into sign and magnitude, flags errors.
module rau_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rau_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          q_full,
    output logic                          q_push,
    output rau_pkg::item_t                q_item
);

    function automatic rau_pkg::smag_t to_smag(input logic [rau_pkg::OPND_W-1:0] x);
        rau_pkg::smag_t r;
        r.neg = x[rau_pkg::OPND_W-1];
        r.mag = r.neg ? (~x + 1'b1) : x;
        return r;
    endfunction

    logic [rau_pkg::CMD_W-1:0] cmd;
    rau_pkg::smag_t an, ad, bn, bd;
    logic uses_b;

    assign cmd = s_tdata[2:0];
    assign an  = to_smag(s_tdata[34:3]);
    assign ad  = to_smag(s_tdata[66:35]);
    assign bn  = to_smag(s_tdata[98:67]);
    assign bd  = to_smag(s_tdata[130:99]);
    assign uses_b = (cmd == rau_pkg::CMD_ADD) || (cmd == rau_pkg::CMD_SUB) ||
                    (cmd == rau_pkg::CMD_MUL) || (cmd == rau_pkg::CMD_DIV);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_item.cmd     = cmd;
        q_item.an      = an;
        q_item.ad      = ad;
        q_item.bn      = bn;
        q_item.bd      = bd;
        q_item.dens_ok = (ad.mag != '0) && (bd.mag != '0);
        q_item.err     = (ad.mag == '0) || (uses_b && (bd.mag == '0)) ||
                         ((cmd == rau_pkg::CMD_DIV) && (bn.mag == '0));
    end

endmodule

>>> sv/rau_queue.sv
// Short queue of classified items between front and back.
module rau_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  rau_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output rau_pkg::item_t head_item
);

    rau_pkg::item_t entry_reg [rau_pkg::Q_DEPTH];
    logic [rau_pkg::Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [rau_pkg::Q_CNT_W-1:0] count_reg;

    assign full      = (count_reg == rau_pkg::Q_CNT_W'(rau_pkg::Q_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> sv/rau_back.sv
// Back end: multiply, compare, combine, binary gcd, exact divide, and the output register.
module rau_back #(
    parameter int FIELD_WIDTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_empty,
    input  rau_pkg::item_t               q_item,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [rau_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int W = rau_pkg::WIDE_W;
    localparam logic [W-1:0] LIM = W'((64'd1 << (FIELD_WIDTH - 1)) - 64'd1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MULT = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_FORM = 3'd3;
    localparam logic [2:0] ST_GCD  = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] step_reg;
    logic [5:0] cnt_reg;
    logic [5:0] k_reg;

    rau_pkg::item_t it_reg;
    logic [W-1:0] p0_reg, p1_reg, pn_reg, pd_reg;
    logic [W-1:0] u_reg, v_reg, g_reg;
    logic [W-1:0] nmag_reg, dmag_reg;
    logic         rneg_reg;
    logic         err_reg;
    logic [rau_pkg::CODE_W-1:0] order_reg;
    logic [W-1:0] qn_reg, qd_reg, rn_reg, rd_reg;

    logic                             out_valid_reg;
    logic [rau_pkg::OPND_W-1:0]       out_num_reg;
    logic [rau_pkg::RDEN_W-1:0]       out_den_reg;
    logic [rau_pkg::CODE_W-1:0]       out_status_reg;
    logic [rau_pkg::CODE_W-1:0]       out_order_reg;

    logic [rau_pkg::OPND_W-1:0] mul_a, mul_b;
    logic [W-1:0] mul_p;
    logic out_free;

    // signed products used by compare and combine
    logic p0_neg, p1_neg, p1_neg_eff, pn_neg, pd_neg;
    logic cmp_gt, cmp_lt;
    logic         n_neg;
    logic [W-1:0] n_mag, d_mag;
    logic         d_neg;

    logic [W:0] tn, td;
    logic [W-1:0] nm, dm;
    logic         ovf;

    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;

    always_comb begin
        case (step_reg)
            2'd0:    begin mul_a = it_reg.an.mag; mul_b = it_reg.bd.mag; end
            2'd1:    begin mul_a = it_reg.bn.mag; mul_b = it_reg.ad.mag; end
            2'd2:    begin mul_a = it_reg.an.mag; mul_b = it_reg.bn.mag; end
            default: begin
                mul_a = it_reg.ad.mag;
                mul_b = (it_reg.cmd == rau_pkg::CMD_DIV) ? it_reg.bn.mag : it_reg.bd.mag;
            end
        endcase
        mul_p = W'(mul_a) * W'(mul_b);
    end

    always_comb begin
        p0_neg = (p0_reg != '0) && (it_reg.an.neg ^ it_reg.bd.neg);
        p1_neg = (p1_reg != '0) && (it_reg.bn.neg ^ it_reg.ad.neg);
        pn_neg = (pn_reg != '0) && (it_reg.an.neg ^ it_reg.bn.neg);
        if (it_reg.cmd == rau_pkg::CMD_DIV) begin
            pd_neg = it_reg.ad.neg ^ it_reg.bn.neg;
        end else begin
            pd_neg = it_reg.ad.neg ^ it_reg.bd.neg;
        end
        if (p0_neg != p1_neg) begin
            cmp_gt = !p0_neg;
            cmp_lt = p0_neg;
        end else if (p0_reg == p1_reg) begin
            cmp_gt = 1'b0;
            cmp_lt = 1'b0;
        end else begin
            cmp_gt = (p0_reg > p1_reg) ^ p0_neg;
            cmp_lt = !cmp_gt;
        end
    end

    always_comb begin
        p1_neg_eff = p1_neg ^ (it_reg.cmd == rau_pkg::CMD_SUB);
        n_neg = 1'b0;
        n_mag = '0;
        d_mag = pd_reg;
        d_neg = pd_neg;
        case (it_reg.cmd)
            rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
                if (p0_neg == p1_neg_eff) begin
                    n_neg = p0_neg;
                    n_mag = p0_reg + p1_reg;
                end else if (p0_reg >= p1_reg) begin
                    n_neg = p0_neg;
                    n_mag = p0_reg - p1_reg;
                end else begin
                    n_neg = p1_neg_eff;
                    n_mag = p1_reg - p0_reg;
                end
            end
            rau_pkg::CMD_MUL: begin
                n_neg = pn_neg;
                n_mag = pn_reg;
            end
            rau_pkg::CMD_DIV: begin
                n_neg = p0_neg;
                n_mag = p0_reg;
            end
            rau_pkg::CMD_NEG: begin
                n_neg = !it_reg.an.neg;
                n_mag = W'(it_reg.an.mag);
                d_mag = W'(it_reg.ad.mag);
                d_neg = it_reg.ad.neg;
            end
            default: begin
                n_neg = it_reg.an.neg;
                n_mag = W'(it_reg.an.mag);
                d_mag = W'(it_reg.ad.mag);
                d_neg = it_reg.ad.neg;
            end
        endcase
    end

    assign tn = {rn_reg, qn_reg[W-1]} - {1'b0, g_reg};
    assign td = {rd_reg, qd_reg[W-1]} - {1'b0, g_reg};

    always_comb begin
        nm  = qn_reg;
        dm  = (qn_reg == '0) ? W'(1) : qd_reg;
        ovf = (dm > LIM) || (nm > (rneg_reg ? LIM + 1'b1 : LIM));
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (!q_empty) state_next = ST_MULT;
            ST_MULT: if (step_reg == 2'd3) state_next = ST_CMP;
            ST_CMP:  state_next = ST_FORM;
            ST_FORM: state_next = err_reg ? ST_OUT : ST_GCD;
            ST_GCD:  if (u_reg == '0 || v_reg == '0) state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == 6'd63) state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                it_reg   <= q_item;
                err_reg  <= q_item.err;
                step_reg <= 2'd0;
            end
            ST_MULT: begin
                step_reg <= step_reg + 1'b1;
                case (step_reg)
                    2'd0:    p0_reg <= mul_p;
                    2'd1:    p1_reg <= mul_p;
                    2'd2:    pn_reg <= mul_p;
                    default: pd_reg <= mul_p;
                endcase
            end
            ST_CMP: begin
                if (!it_reg.dens_ok) begin
                    order_reg <= rau_pkg::ORD_EQ;
                end else if ((cmp_gt && !(it_reg.ad.neg ^ it_reg.bd.neg)) ||
                             (cmp_lt && (it_reg.ad.neg ^ it_reg.bd.neg))) begin
                    order_reg <= rau_pkg::ORD_GT;
                end else if (cmp_gt || cmp_lt) begin
                    order_reg <= rau_pkg::ORD_LT;
                end else begin
                    order_reg <= rau_pkg::ORD_EQ;
                end
            end
            ST_FORM: begin
                nmag_reg <= n_mag;
                dmag_reg <= d_mag;
                u_reg    <= n_mag;
                v_reg    <= d_mag;
                k_reg    <= '0;
                rneg_reg <= (n_mag != '0) && (n_neg != d_neg);
            end
            ST_GCD: begin
                if (u_reg == '0 || v_reg == '0) begin
                    g_reg   <= (u_reg | v_reg) << k_reg;
                    qn_reg  <= nmag_reg;
                    qd_reg  <= dmag_reg;
                    rn_reg  <= '0;
                    rd_reg  <= '0;
                    cnt_reg <= '0;
                end else if (!u_reg[0] && !v_reg[0]) begin
                    u_reg <= u_reg >> 1;
                    v_reg <= v_reg >> 1;
                    k_reg <= k_reg + 1'b1;
                end else if (!u_reg[0]) begin
                    u_reg <= u_reg >> 1;
                end else if (!v_reg[0]) begin
                    v_reg <= v_reg >> 1;
                end else if (u_reg >= v_reg) begin
                    u_reg <= u_reg - v_reg;
                end else begin
                    v_reg <= v_reg - u_reg;
                end
            end
            ST_DIV: begin
                cnt_reg <= cnt_reg + 1'b1;
                if (!tn[W]) begin
                    rn_reg <= tn[W-1:0];
                    qn_reg <= {qn_reg[W-2:0], 1'b1};
                end else begin
                    rn_reg <= {rn_reg[W-2:0], qn_reg[W-1]};
                    qn_reg <= {qn_reg[W-2:0], 1'b0};
                end
                if (!td[W]) begin
                    rd_reg <= td[W-1:0];
                    qd_reg <= {qd_reg[W-2:0], 1'b1};
                end else begin
                    rd_reg <= {rd_reg[W-2:0], qd_reg[W-1]};
                    qd_reg <= {qd_reg[W-2:0], 1'b0};
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    out_order_reg <= order_reg;
                    if (err_reg) begin
                        out_status_reg <= rau_pkg::ST_ZERO_DEN;
                        out_num_reg    <= '0;
                        out_den_reg    <= '0;
                    end else if (ovf) begin
                        out_status_reg <= rau_pkg::ST_OVERFLOW;
                        out_num_reg    <= '0;
                        out_den_reg    <= '0;
                    end else begin
                        out_status_reg <= rau_pkg::ST_OK;
                        out_num_reg    <= rneg_reg ? (~nm[rau_pkg::OPND_W-1:0] + 1'b1)
                                                   : nm[rau_pkg::OPND_W-1:0];
                        out_den_reg    <= dm[rau_pkg::RDEN_W-1:0];
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_order_reg, out_status_reg, out_den_reg, out_num_reg};

endmodule
